[design/dler_pkg.sv]
// Package: shared types and register codes for the delay-line echo/reverb unit.
package dler_pkg;

    // Register indexes on the configuration port.
    localparam int unsigned REG_EFFECT_MODE = 0;
    localparam int unsigned REG_COUNT       = 1;

    // Effect selection held in the effect_mode register.
    typedef enum logic {
        MODE_ECHO   = 1'b0,
        MODE_REVERB = 1'b1
    } mode_t;

    // Sideband that travels with each tap read until its data returns.
    typedef struct packed {
        logic first;   // first tap of a sample: start from the dry half
        logic last;    // last tap of a sample: result goes to the output
        logic live;    // entry written since reset; otherwise reads as zero
        logic deep;    // weight 1/8 when set, 1/4 otherwise
    } tap_tag_t;

endpackage

[design/dler_if.sv]
// Interfaces: valid/ready channels for stereo input and stereo output requests.
interface dler_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface dler_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

[design/dler_ram.sv]
// Generic single-port RAM with registered read data.
module dler_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 5000
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

[design/delay_line_echo_reverb_unit.sv]
// Top level: stereo-to-mono delay line with single-tap echo and three-tap reverb.
// Each request takes one write plus three tap reads through the single port of the delay
//   RAM in reverb mode, and one write plus one tap read in echo mode. The next request can
//   be accepted as the last read issues; that read waits while the output holds a result.
// Reset: rst_n is asynchronous, active low; write position and fill flag clear,
//   effect_mode resets to reverb. The RAM itself is not swept: until the write
//   position first wraps, taps above it read as zero, so no clearing pass is needed.
module delay_line_echo_reverb_unit #(
    parameter int DELAY_DEPTH  = 5000,
    parameter int SAMPLE_BITS  = 24,
    parameter int ECHO_TAP     = 1,
    parameter int REVERB_TAP_A = 6000,
    parameter int REVERB_TAP_B = 5000,
    parameter int REVERB_TAP_C = 4000
) (
    input  logic        clk,
    input  logic        rst_n,
    dler_in_if.sink     in_ch,
    dler_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int S  = SAMPLE_BITS;

    // Tap offsets reduced modulo the depth at elaboration.
    localparam logic [AW-1:0] ECHO_OFF  = AW'(ECHO_TAP % DELAY_DEPTH);
    localparam logic [AW-1:0] TAP_A_OFF = AW'(REVERB_TAP_A % DELAY_DEPTH);
    localparam logic [AW-1:0] TAP_B_OFF = AW'(REVERB_TAP_B % DELAY_DEPTH);
    localparam logic [AW-1:0] TAP_C_OFF = AW'(REVERB_TAP_C % DELAY_DEPTH);
    localparam logic [AW:0]   DEPTH_V   = (AW+1)'(DELAY_DEPTH);
    localparam logic [AW-1:0] LAST_POS  = AW'(DELAY_DEPTH - 1);

    // Sequencer steps: one RAM access per step.
    typedef enum logic [1:0] {
        STEP_WRITE,
        STEP_TAP_A,
        STEP_TAP_B,
        STEP_TAP_C
    } step_t;

    // ------------------------------------------------------------------
    // Configuration port. Single register at word 0; pready tied high.
    // ------------------------------------------------------------------
    dler_pkg::mode_t effect_mode_reg;
    logic            cfg_write;
    logic            cfg_hit;

    assign pready    = 1'b1;
    assign cfg_hit   = (32'(paddr[2]) == 32'(dler_pkg::REG_EFFECT_MODE));
    assign cfg_write = psel && penable && pwrite && cfg_hit;
    assign prdata    = cfg_hit ? 32'(effect_mode_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_mode_reg <= dler_pkg::MODE_REVERB;
        end
        else if (cfg_write)
        begin
            effect_mode_reg <= dler_pkg::mode_t'(pwdata[0]);
        end
    end

    // ------------------------------------------------------------------
    // Input mix: mono = (L + R) / 2, truncated toward zero.
    // ------------------------------------------------------------------
    logic signed [S:0]   lr_sum;
    logic signed [S:0]   lr_biased;
    logic signed [S-1:0] mono_in;

    assign lr_sum    = {in_ch.left_sample[S-1], in_ch.left_sample}
                     + {in_ch.right_sample[S-1], in_ch.right_sample};
    assign lr_biased = lr_sum + (S+1)'(lr_sum[S]);
    assign mono_in   = S'(lr_biased >>> 1);

    // ------------------------------------------------------------------
    // Sequencer: write the mono sample, then issue the tap reads.
    // ------------------------------------------------------------------
    logic                busy_reg;
    step_t               step_reg;
    logic [AW-1:0]       pos_reg;      // write position of the current sample
    logic                filled_reg;   // every RAM entry written at least once
    logic signed [S-1:0] mono_reg;

    logic          echo_mode;
    logic          last_step;
    logic          out_free;
    logic          issue;
    logic          last_issue;
    logic          accept;
    logic [AW-1:0] tap_off;
    logic [AW:0]   addr_sum;
    logic [AW:0]   addr_wrap;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [S-1:0]  mem_rdata;

    assign echo_mode  = (effect_mode_reg == dler_pkg::MODE_ECHO);
    assign last_step  = (step_reg == STEP_TAP_C) || (step_reg == STEP_TAP_A && echo_mode);
    // The last read passes the registered RAM read and its tap tag before it lands in the
    // output register; hold it back until that register is empty or being drained.
    assign out_free   = !out_ch.valid || out_ch.ready;
    assign issue      = busy_reg && (!last_step || out_free);
    assign last_issue = issue && last_step;
    assign in_ch.ready = !busy_reg || last_issue;
    assign accept     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        case (step_reg)
            STEP_TAP_A: tap_off = echo_mode ? ECHO_OFF : TAP_A_OFF;
            STEP_TAP_B: tap_off = TAP_B_OFF;
            STEP_TAP_C: tap_off = TAP_C_OFF;
            default:    tap_off = '0;
        endcase
    end

    assign addr_sum  = {1'b0, pos_reg} + {1'b0, tap_off};
    assign addr_wrap = (addr_sum >= DEPTH_V) ? (addr_sum - DEPTH_V) : addr_sum;
    assign rd_addr   = addr_wrap[AW-1:0];
    assign mem_we    = (step_reg == STEP_WRITE);
    assign mem_addr  = mem_we ? pos_reg : rd_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= STEP_WRITE;
            pos_reg    <= '0;
            filled_reg <= 1'b0;
        end
        else
        begin
            if (issue && !last_step)
            begin
                step_reg <= step_t'(step_reg + 2'd1);
            end
            if (last_issue)
            begin
                busy_reg <= 1'b0;
                pos_reg  <= (pos_reg == LAST_POS) ? '0 : pos_reg + AW'(1);
                if (pos_reg == LAST_POS)
                begin
                    filled_reg <= 1'b1;
                end
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_WRITE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mono_reg <= mono_in;
        end
    end

    dler_ram #(
        .WIDTH (S),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .en    (issue),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mono_reg),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Tap return: tag registered alongside the RAM read.
    // ------------------------------------------------------------------
    logic                tag_valid_reg;
    dler_pkg::tap_tag_t  tag_reg;
    dler_pkg::tap_tag_t  tag_next;
    logic signed [S-1:0] half_reg;     // dry half of the sample the tap belongs to
    logic signed [S:0]   mono_biased;

    assign mono_biased = {mono_reg[S-1], mono_reg} + (S+1)'(mono_reg[S-1]);

    always_comb
    begin
        tag_next.first = (step_reg == STEP_TAP_A);
        tag_next.last  = last_step;
        // Before the first wrap only entries up to the current position hold data.
        tag_next.live  = filled_reg || (rd_addr <= pos_reg);
        tag_next.deep  = (step_reg != STEP_TAP_A);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_valid_reg <= 1'b0;
            tag_reg       <= '0;
        end
        else
        begin
            tag_valid_reg <= issue && !mem_we;
            if (issue && !mem_we)
            begin
                tag_reg <= tag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue && !mem_we)
        begin
            half_reg <= S'(mono_biased >>> 1);
        end
    end

    // ------------------------------------------------------------------
    // Accumulate scaled taps; each term truncates toward zero.
    // ------------------------------------------------------------------
    logic signed [S-1:0] tap_val;
    logic signed [S:0]   tap_biased;
    logic signed [S-1:0] tap_term;
    logic signed [S+1:0] acc_reg;
    logic signed [S+1:0] acc_base;
    logic signed [S+1:0] acc_next;
    logic                out_valid_reg;
    logic signed [S-1:0] out_data_reg;

    assign tap_val    = tag_reg.live ? $signed(mem_rdata) : '0;
    assign tap_biased = {tap_val[S-1], tap_val}
                      + (tap_val[S-1] ? (tag_reg.deep ? (S+1)'(7) : (S+1)'(3)) : '0);
    assign tap_term   = S'(tag_reg.deep ? (tap_biased >>> 3) : (tap_biased >>> 2));
    assign acc_base   = tag_reg.first ? (S+2)'(half_reg) : acc_reg;
    assign acc_next   = acc_base + (S+2)'(tap_term);

    always_ff @(posedge clk)
    begin
        if (tag_valid_reg && !tag_reg.last)
        begin
            acc_reg <= acc_next;
        end
        if (tag_valid_reg && tag_reg.last)
        begin
            out_data_reg <= S'(acc_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tag_valid_reg && tag_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.left_out  = out_data_reg;
    assign out_ch.right_out = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A finished sum never lands on a result still waiting to be taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        tag_valid_reg && tag_reg.last |-> !out_valid_reg || out_ch.ready)
        else $error("result overwritten before it was taken");

    // The write position stays inside the delay line.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < DELAY_DEPTH)
        else $error("write position out of range");

    // An accepted sample starts with its RAM write in the next cycle.
    a_write_first: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && step_reg == STEP_WRITE)
        else $error("accepted sample did not start with a write");

    // A tap read is only issued while a sample is in work.
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tag_valid_reg |-> $past(busy_reg))
        else $error("tap returned without a sample in work");

endmodule
